// ===== src/satellite_tracking_table_assert.svh =====
// Assertion macros for the satellite tracking table
`ifndef SATELLITE_TRACKING_TABLE_ASSERT_SVH
`define SATELLITE_TRACKING_TABLE_ASSERT_SVH

`define STT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/stt_pkg.sv =====
package stt_pkg;

    localparam int unsigned DEPTH_DEFAULT = 32;
    localparam logic [15:0] AGE_LIMIT_RESET = 16'd5000;

    localparam logic [2:0] SYS_GPS  = 3'd0;
    localparam logic [2:0] SYS_QZSS = 3'd4;
    localparam logic [9:0] QZSS_LO  = 10'd193;
    localparam logic [9:0] QZSS_HI  = 10'd202;

    typedef enum logic [1:0] {
        OP_VIEW   = 2'd0,
        OP_MARK   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_EXPIRE = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_REPLACED = 3'd2,
        ST_IGNORED  = 3'd3,
        ST_CLEARED  = 3'd4,
        ST_EXPIRED  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_OLDEST,
        S_WRITE,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0] system;
        logic [9:0] number;
        logic [7:0] elev;
        logic [9:0] azim;
        logic [6:0] cn0;
        logic       has_cn0;
        logic       used;
    } t_info;

endpackage

// ===== src/stt_if.sv =====
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [2:0] sat_system;
    logic [9:0] sat_number;
    logic signed [7:0] elevation;
    logic signed [9:0] azimuth;
    logic [6:0] signal_cn0;
    logic       cn0_present;
    logic [31:0] now_ms;
    modport source (output valid, opcode, sat_system, sat_number, elevation, azimuth,
                    signal_cn0, cn0_present, now_ms, input ready);
    modport sink (input valid, opcode, sat_system, sat_number, elevation, azimuth,
                  signal_cn0, cn0_present, now_ms, output ready);
endinterface

interface stt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [4:0] slot;
    logic [5:0] entry_count;
    logic [5:0] removed_count;
    modport source (output valid, status, slot, entry_count, removed_count, input ready);
    modport sink (input valid, status, slot, entry_count, removed_count, output ready);
endinterface

// ===== src/satellite_tracking_table.sv =====
// Satellite tracking table.
// Requests enter on i_req (valid/ready) and each gives exactly one result on o_rsp.
// Configuration: i_cfg_we with i_cfg_data writes the age limit in ms (reset 5000);
// write it only while no request is in flight.
// One request at a time. The table sits in two one-read-port memories, so each
// request walks its entries one per cycle through the read pipeline:
//   view/mark: reads up to N entries (N = entries, up to TABLE_DEPTH),
//              then a pass over the whole table when it is full, to find its oldest entry;
//   clear:     reads all N entries, read-modify-write of each entry;
//   expire:    reads all N entries, survivors are copied down in order as they are read.
// Ignored requests (number zero) go straight to the result and change nothing.
// The result is held in an output register until taken; a stalled receiver
// holds the block after that one result, and the next request is accepted
// in the cycle the result is taken.
// Reset empties the table at once (count to zero); entries are not cleared.
// Positions on the result give their low bits when TABLE_DEPTH > 32, counts when TABLE_DEPTH > 63.
module satellite_tracking_table #(
    parameter int unsigned TABLE_DEPTH = stt_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    stt_in_if.sink      i_req,
    stt_out_if.source   o_rsp
);
    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    stt_pkg::t_info info_mem [TABLE_DEPTH];
    logic [31:0]    time_mem [TABLE_DEPTH];

    stt_pkg::t_state r_state, n_state;
    logic [15:0]   r_age;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ridx;
    logic          r_rv;
    logic [AW-1:0] r_rpos;
    logic [CW-1:0] r_wptr;
    logic [CW-1:0] r_removed;
    logic [AW-1:0] r_best;
    logic [31:0]   r_best_t;
    logic          r_found;
    logic [AW-1:0] r_hit;
    logic          r_best_pend;

    logic [1:0]  r_op;
    logic [2:0]  r_sys;
    logic [9:0]  r_num;
    logic [7:0]  r_elev;
    logic [9:0]  r_azim;
    logic [6:0]  r_cn0;
    logic        r_cnp;
    logic [31:0] r_now;

    stt_pkg::t_info rd_info;
    logic [31:0]    rd_time;

    logic [2:0] r_o_status;
    logic [4:0] r_o_slot;
    logic       r_o_valid;

    logic in_fire, out_fire;
    assign in_fire  = i_req.valid && i_req.ready;
    assign out_fire = r_o_valid && o_rsp.ready;
    assign i_req.ready = (r_state == stt_pkg::S_IDLE) && (!r_o_valid || o_rsp.ready);

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.slot          = r_o_slot;
    assign o_rsp.entry_count   = 6'(r_count);
    assign o_rsp.removed_count = (r_o_status == stt_pkg::ST_EXPIRED) ? 6'(r_removed) : 6'd0;

    logic rd_en, wr_en, tw_en;
    logic [AW-1:0] rd_addr, wr_addr;
    stt_pkg::t_info wr_info;
    logic [31:0]    wr_time;

    logic scan_go, match, expired, cmatch;
    assign scan_go = r_ridx < ((r_state == stt_pkg::S_OLDEST) ? DEPTH_C : r_count);
    assign match   = rd_info.system == r_sys && rd_info.number == r_num;
    assign expired = (r_now - rd_time) > {16'd0, r_age};
    assign cmatch  = rd_info.system == r_sys ||
                     (r_sys == stt_pkg::SYS_GPS && rd_info.system == stt_pkg::SYS_QZSS);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            rd_info <= info_mem[rd_addr];
            rd_time <= time_mem[rd_addr];
        end
        if (wr_en) info_mem[wr_addr] <= wr_info;
        if (tw_en) time_mem[wr_addr] <= wr_time;
    end

    always_comb begin
        rd_en   = (r_state == stt_pkg::S_SCAN || r_state == stt_pkg::S_OLDEST ||
                   r_state == stt_pkg::S_SWEEP) && scan_go;
        rd_addr = r_ridx[AW-1:0];
        wr_en   = 1'b0;
        tw_en   = 1'b0;
        wr_addr = r_rpos;
        wr_info = rd_info;
        wr_time = rd_time;
        n_state = r_state;
        unique case (r_state)
            stt_pkg::S_IDLE: begin
                if (in_fire) n_state = stt_pkg::S_SCAN;
            end
            stt_pkg::S_SCAN: begin
                if ((r_op == stt_pkg::OP_VIEW || r_op == stt_pkg::OP_MARK) &&
                    r_num == 10'd0) begin
                    n_state = stt_pkg::S_DONE;
                end else if (r_op == stt_pkg::OP_CLEAR) begin
                    if (r_rv) begin
                        wr_en = 1'b1;
                        wr_info.used = rd_info.used & ~cmatch;
                    end
                    if (!scan_go && !r_rv) n_state = stt_pkg::S_DONE;
                end else if (r_op == stt_pkg::OP_EXPIRE) begin
                    if (r_rv && !expired) begin
                        wr_en = 1'b1;
                        tw_en = 1'b1;
                        wr_addr = r_wptr[AW-1:0];
                    end
                    if (!scan_go && !r_rv) n_state = stt_pkg::S_DONE;
                end else begin
                    if (r_rv && match) n_state = stt_pkg::S_WRITE;
                    else if (!scan_go && !r_rv) begin
                        n_state = (r_count < DEPTH_C) ? stt_pkg::S_WRITE : stt_pkg::S_OLDEST;
                    end
                end
            end
            stt_pkg::S_OLDEST: begin
                if (!scan_go && !r_rv) n_state = stt_pkg::S_WRITE;
            end
            stt_pkg::S_WRITE: begin
                rd_en = 1'b1;
                rd_addr = r_hit;
                n_state = stt_pkg::S_SWEEP;
            end
            stt_pkg::S_SWEEP: begin
                rd_en = 1'b0;
                wr_en = 1'b1;
                wr_addr = r_hit;
                wr_info = rd_info;
                wr_time = rd_time;
                if (!r_found) begin
                    wr_info.system = r_sys;
                    wr_info.number = r_num;
                    wr_info.elev = 8'hFF;
                    wr_info.azim = 10'h3FF;
                    wr_info.cn0 = 7'd0;
                    wr_info.has_cn0 = 1'b0;
                    wr_info.used = 1'b0;
                    wr_time = r_now;
                    tw_en = 1'b1;
                end
                if (r_op == stt_pkg::OP_VIEW) begin
                    wr_info.elev = r_elev;
                    wr_info.azim = r_azim;
                    wr_info.cn0 = r_cn0;
                    wr_info.has_cn0 = r_cnp;
                    wr_time = r_now;
                    tw_en = 1'b1;
                end else begin
                    wr_info.used = 1'b1;
                end
                n_state = stt_pkg::S_DONE;
            end
            stt_pkg::S_DONE: begin
                rd_en = 1'b0;
                n_state = stt_pkg::S_IDLE;
            end
            default: n_state = stt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= stt_pkg::S_IDLE;
            r_age     <= stt_pkg::AGE_LIMIT_RESET;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_rv      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_age <= i_cfg_data;
            if (out_fire) r_o_valid <= 1'b0;
            r_rv <= rd_en;
            if (rd_en) begin
                r_ridx <= r_ridx + 1'b1;
                r_rpos <= r_ridx[AW-1:0];
            end
            if (in_fire) begin
                r_op     <= i_req.opcode;
                r_sys    <= (i_req.opcode != stt_pkg::OP_CLEAR &&
                             i_req.sat_system == stt_pkg::SYS_GPS &&
                             i_req.sat_number >= stt_pkg::QZSS_LO &&
                             i_req.sat_number <= stt_pkg::QZSS_HI) ?
                            stt_pkg::SYS_QZSS : i_req.sat_system;
                r_num    <= i_req.sat_number;
                r_elev   <= i_req.elevation;
                r_azim   <= i_req.azimuth;
                r_cn0    <= i_req.signal_cn0;
                r_cnp    <= i_req.cn0_present;
                r_now    <= i_req.now_ms;
                r_ridx   <= '0;
                r_wptr   <= '0;
                r_removed <= '0;
                r_found  <= 1'b0;
            end
            unique case (r_state)
                stt_pkg::S_SCAN: begin
                    if (r_op == stt_pkg::OP_EXPIRE && r_rv) begin
                        if (expired) r_removed <= r_removed + 1'b1;
                        else r_wptr <= r_wptr + 1'b1;
                    end
                    if ((r_op == stt_pkg::OP_VIEW || r_op == stt_pkg::OP_MARK) &&
                        r_num != 10'd0) begin
                        if (r_rv && match) begin
                            r_found <= 1'b1;
                            r_hit <= r_rpos;
                            r_ridx <= r_ridx;
                        end else if (!scan_go && !r_rv) begin
                            r_hit <= r_count[AW-1:0];
                            r_ridx <= '0;
                        end
                    end
                end
                stt_pkg::S_OLDEST: begin
                    if (r_rv && (r_rpos == '0 || rd_time < r_best_t)) begin
                        r_best <= r_rpos;
                        r_best_t <= rd_time;
                    end
                    if (!scan_go && !r_rv) r_hit <= r_best;
                end
                stt_pkg::S_WRITE: begin
                    if (!r_found && r_count < DEPTH_C) r_count <= r_count + 1'b1;
                end
                default: ;
            endcase
            if (r_state == stt_pkg::S_SCAN && n_state == stt_pkg::S_DONE &&
                r_op == stt_pkg::OP_EXPIRE) begin
                r_count <= r_wptr;
            end
            if (r_state == stt_pkg::S_DONE) begin
                r_o_valid <= 1'b1;
                r_o_slot  <= 5'd0;
                if (r_op == stt_pkg::OP_CLEAR) r_o_status <= stt_pkg::ST_CLEARED;
                else if (r_op == stt_pkg::OP_EXPIRE) r_o_status <= stt_pkg::ST_EXPIRED;
                else if (r_num == 10'd0) r_o_status <= stt_pkg::ST_IGNORED;
                else begin
                    r_o_slot <= 5'(r_hit);
                    r_o_status <= r_found ? stt_pkg::ST_UPDATED :
                                  (r_count == DEPTH_C && r_best_pend) ?
                                  stt_pkg::ST_REPLACED : stt_pkg::ST_INSERTED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_best_pend <= 1'b0;
        else if (in_fire) r_best_pend <= 1'b0;
        else if (r_state == stt_pkg::S_OLDEST) r_best_pend <= 1'b1;
    end

    `include "satellite_tracking_table_assert.svh"

    `STT_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C, "count overflow")
    `STT_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != stt_pkg::S_IDLE, !i_req.ready, "ready while busy")
    `STT_ASSERT_NEXT(a_done_result, i_clk, i_rst_n, r_state == stt_pkg::S_DONE, r_o_valid, "result not raised")
endmodule

// ===== tb/satellite_tracking_table_tb.sv =====
module satellite_tracking_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        stt_pkg::t_status status;
        logic [4:0]       slot;
        logic [5:0]       count;
        logic [5:0]       removed;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;

    stt_in_if  req ();
    stt_out_if rsp ();

    satellite_tracking_table u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req.sink),
        .o_rsp      (rsp.source)
    );

    t_result        expected_q[$];
    stt_pkg::t_info sat_info[DEPTH];
    logic [31:0]    sat_time[DEPTH];
    int             sat_count;
    logic [15:0]    age_limit;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          mismatches;
    int          requests_sent;
    int          results_seen;
    logic [31:0] clock_ms;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    function automatic t_result track_request(stt_pkg::t_opcode op, logic [2:0] sys,
                                              logic [9:0] num, logic [7:0] el,
                                              logic [9:0] az, logic [6:0] cn0,
                                              logic pres, logic [31:0] now);
        t_result     r;
        int          pos;
        int          w;
        int          removed;
        logic [2:0]  key_sys;
        logic [31:0] age;
        r.status = stt_pkg::ST_IGNORED;
        r.slot = '0;
        r.removed = '0;
        pos = -1;
        key_sys = sys;
        removed = 0;
        case (op) inside
            stt_pkg::OP_VIEW, stt_pkg::OP_MARK: begin
                if (num != 0) begin
                    if (sys == stt_pkg::SYS_GPS && num >= stt_pkg::QZSS_LO &&
                        num <= stt_pkg::QZSS_HI)
                        key_sys = stt_pkg::SYS_QZSS;
                    for (int i = 0; i < sat_count; i++)
                        if (pos < 0 && sat_info[i].system == key_sys &&
                            sat_info[i].number == num)
                            pos = i;
                    r.status = stt_pkg::ST_UPDATED;
                    if (pos < 0) begin
                        if (sat_count < DEPTH) begin
                            pos = sat_count;
                            sat_count++;
                            r.status = stt_pkg::ST_INSERTED;
                        end else begin
                            pos = 0;
                            for (int i = 1; i < DEPTH; i++)
                                if (sat_time[i] < sat_time[pos])
                                    pos = i;
                            r.status = stt_pkg::ST_REPLACED;
                        end
                        sat_info[pos] = '{key_sys, num, 8'hFF, 10'h3FF, 7'd0, 1'b0, 1'b0};
                        sat_time[pos] = now;
                    end
                    if (op == stt_pkg::OP_VIEW) begin
                        sat_info[pos].elev = el;
                        sat_info[pos].azim = az;
                        sat_info[pos].cn0 = cn0;
                        sat_info[pos].has_cn0 = pres;
                        sat_time[pos] = now;
                    end else begin
                        sat_info[pos].used = 1'b1;
                    end
                    r.slot = pos[4:0];
                end
            end
            stt_pkg::OP_CLEAR: begin
                for (int i = 0; i < sat_count; i++)
                    if (sat_info[i].system == sys
                        || (sys == stt_pkg::SYS_GPS && sat_info[i].system == stt_pkg::SYS_QZSS))
                        sat_info[i].used = 1'b0;
                r.status = stt_pkg::ST_CLEARED;
            end
            default: begin
                w = 0;
                for (int i = 0; i < sat_count; i++) begin
                    age = now - sat_time[i];
                    if (age > {16'd0, age_limit}) begin
                        removed++;
                    end else begin
                        sat_info[w] = sat_info[i];
                        sat_time[w] = sat_time[i];
                        w++;
                    end
                end
                sat_count = w;
                r.status = stt_pkg::ST_EXPIRED;
                r.removed = removed[5:0];
            end
        endcase
        r.count = sat_count[5:0];
        return r;
    endfunction

    task automatic send_request(stt_pkg::t_opcode op, logic [2:0] sys, logic [9:0] num,
                                logic [7:0] el, logic [9:0] az, logic [6:0] cn0,
                                logic pres, logic [31:0] now);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge i_clk);
        req.valid = 1'b1;
        req.opcode = op;
        req.sat_system = sys;
        req.sat_number = num;
        req.elevation = el;
        req.azimuth = az;
        req.signal_cn0 = cn0;
        req.cn0_present = pres;
        req.now_ms = now;
        forever begin
            #1;
            if (req.ready) begin
                @(posedge i_clk);
                break;
            end
            @(negedge i_clk);
        end
        expected_q.push_back(track_request(op, sys, num, el, az, cn0, pres, now));
        requests_sent++;
        @(negedge i_clk);
        req.valid = 1'b0;
    endtask

    task automatic drain;
        wait (expected_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_age_limit(logic [15:0] value);
        drain();
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
        age_limit = value;
    endtask

    task automatic send_view(logic [2:0] sys, logic [9:0] num, logic [31:0] now);
        send_request(stt_pkg::OP_VIEW, sys, num, 8'($urandom_range(0, 91) - 1),
                     10'($urandom_range(0, 360) - 1), 7'($urandom_range(0, 99)),
                     1'($urandom), now);
    endtask

    task automatic send_expire(logic [31:0] now);
        send_request(stt_pkg::OP_EXPIRE, 3'd0, 10'd0, 8'd0, 10'd0, 7'd0, 1'b0, now);
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            rsp.ready = 1'b0;
            hold_cycles--;
        end else begin
            rsp.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            got = '{stt_pkg::t_status'(rsp.status), rsp.slot, rsp.entry_count,
                    rsp.removed_count};
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d slot %0d count %0d removed %0d",
                             got.status, got.slot, got.count, got.removed);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected status %0d slot %0d count %0d ",
                                  "removed %0d, got status %0d slot %0d count %0d ",
                                  "removed %0d"},
                                 want.status, want.slot, want.count, want.removed,
                                 got.status, got.slot, got.count, got.removed);
                end
            end
        end
    end

    task automatic test_directed;
        send_request(stt_pkg::OP_VIEW, stt_pkg::SYS_GPS, 10'd0, 8'h7F, 10'h1FF, 7'h7F, 1'b1,
                     32'hFFFF_FFFF);
        send_request(stt_pkg::OP_MARK, 3'd2, 10'd0, 8'h80, 10'h200, 7'h00, 1'b0, 32'd0);
        send_request(stt_pkg::OP_VIEW, stt_pkg::SYS_GPS, 10'd1, 8'd90, 10'd359, 7'd99, 1'b1,
                     32'd1000);
        send_request(stt_pkg::OP_VIEW, stt_pkg::SYS_GPS, 10'd193, 8'hFF, 10'h3FF, 7'd0, 1'b0,
                     32'd1001);
        send_request(stt_pkg::OP_VIEW, stt_pkg::SYS_QZSS, 10'd193, 8'h80, 10'h200, 7'h7F,
                     1'b1, 32'd1002);
        send_request(stt_pkg::OP_MARK, stt_pkg::SYS_GPS, 10'd202, 8'h00, 10'h000, 7'd0, 1'b0,
                     32'd1003);
        send_request(stt_pkg::OP_VIEW, stt_pkg::SYS_GPS, 10'd192, 8'h7F, 10'h1FF, 7'd5, 1'b1,
                     32'd1004);
        send_request(stt_pkg::OP_VIEW, stt_pkg::SYS_GPS, 10'd203, 8'd10, 10'd20, 7'd6, 1'b1,
                     32'd1005);
        send_request(stt_pkg::OP_VIEW, 3'd1, 10'h3FF, 8'd45, 10'd180, 7'd40, 1'b1, 32'd1006);
        send_request(stt_pkg::OP_VIEW, 3'd3, 10'h2AA, 8'd45, 10'd180, 7'd40, 1'b0, 32'd1007);
        send_request(stt_pkg::OP_MARK, 3'd6, 10'h155, 8'd0, 10'd0, 7'd0, 1'b0, 32'd1008);
        send_request(stt_pkg::OP_MARK, 3'd7, 10'd5, 8'd0, 10'd0, 7'd0, 1'b0, 32'd1009);
        send_request(stt_pkg::OP_MARK, stt_pkg::SYS_GPS, 10'd1, 8'd0, 10'd0, 7'd0, 1'b0,
                     32'd1010);
        send_request(stt_pkg::OP_MARK, 3'd5, 10'd5, 8'd0, 10'd0, 7'd0, 1'b0, 32'd1011);
        send_request(stt_pkg::OP_CLEAR, 3'd6, 10'd0, 8'd0, 10'd0, 7'd0, 1'b0, 32'd1012);
        send_request(stt_pkg::OP_CLEAR, stt_pkg::SYS_GPS, 10'd0, 8'd0, 10'd0, 7'd0, 1'b0,
                     32'd1013);
        send_request(stt_pkg::OP_CLEAR, stt_pkg::SYS_GPS, 10'd195, 8'd0, 10'd0, 7'd0, 1'b0,
                     32'd1013);
        send_request(stt_pkg::OP_CLEAR, 3'd7, 10'h3FF, 8'hFF, 10'h3FF, 7'h7F, 1'b1,
                     32'd1014);
        send_request(stt_pkg::OP_MARK, 3'd1, 10'h3FF, 8'd0, 10'd0, 7'd0, 1'b0, 32'd9000);
        send_expire(32'd6005);
        send_expire(32'd6007);
        send_expire(32'd500);
    endtask

    task automatic test_fill_and_replace;
        write_age_limit(16'hFFFF);
        send_expire(32'd100_000);
        for (int i = 0; i < DEPTH; i++)
            send_view(3'(i % 8), 10'(i + 300), (i % 3 == 0) ? 32'd7 : 32'(100 + i));
        send_view(3'd1, 10'd900, 32'd50);
        send_view(3'd2, 10'd901, 32'd60);
        send_request(stt_pkg::OP_MARK, 3'd3, 10'd902, 8'd0, 10'd0, 7'd0, 1'b0, 32'd1);
        send_request(stt_pkg::OP_MARK, 3'd4, 10'd903, 8'd0, 10'd0, 7'd0, 1'b0, 32'd2);
        send_view(3'd0, 10'd305, 32'd3);
        send_expire(32'd70);
        send_expire(32'd300_000);
    endtask

    task automatic test_age_limits;
        write_age_limit(16'd0);
        send_view(3'd2, 10'd11, 32'd100);
        send_view(3'd2, 10'd12, 32'd101);
        send_expire(32'd100);
        send_expire(32'd101);
        send_expire(32'd102);
        write_age_limit(16'hFFFF);
        send_view(3'd3, 10'd13, 32'hFFFF_FFF0);
        send_view(3'd3, 10'd14, 32'hFFFF_FFFF);
        send_expire(32'h0000_FFEF);
        send_expire(32'h0000_FFF0);
        send_expire(32'h0001_0000);
        write_age_limit(16'd5000);
    endtask

    task automatic send_random_request;
        stt_pkg::t_opcode op;
        logic [2:0]       sys;
        logic [9:0]       num;
        logic [7:0]       el;
        logic [9:0]       az;
        int               pick;
        pick = $urandom_range(99);
        op = (pick < 55) ? stt_pkg::OP_VIEW : (pick < 75) ? stt_pkg::OP_MARK :
             (pick < 88) ? stt_pkg::OP_CLEAR : stt_pkg::OP_EXPIRE;
        sys = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        pick = $urandom_range(99);
        num = (pick < 70) ? 10'($urandom_range(1, 40))
            : (pick < 85) ? 10'($urandom_range(190, 205))
            : (pick < 95) ? 10'($urandom) : 10'd0;
        el = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 91) - 1);
        az = ($urandom_range(4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 360) - 1);
        clock_ms += $urandom_range(0, 300);
        if ($urandom_range(49) == 0)
            clock_ms = $urandom;
        send_request(op, sys, num, el, az, 7'($urandom), 1'($urandom), clock_ms);
    endtask

    task automatic test_random;
        int limits[3] = '{16'hFFFF, 16'd3000, 16'd800};
        int idle_tx[3] = '{13, 84, 0};
        int idle_rx[3] = '{84, 13, 0};
        for (int p = 0; p < 3; p++) begin
            write_age_limit(16'(limits[p]));
            send_idle_pct = idle_tx[p];
            recv_idle_pct = idle_rx[p];
            for (int i = 0; i < 580; i++)
                send_random_request();
        end
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 400;
        for (int i = 0; i < 8; i++)
            send_random_request();
        drain();
        for (int i = 0; i < 6; i++)
            send_random_request();
    endtask

    initial begin
        req.valid = 1'b0;
        req.opcode = stt_pkg::OP_VIEW;
        req.sat_system = '0;
        req.sat_number = '0;
        req.elevation = '0;
        req.azimuth = '0;
        req.signal_cn0 = '0;
        req.cn0_present = 1'b0;
        req.now_ms = '0;
        rsp.ready = 1'b0;
        sat_count = 0;
        age_limit = stt_pkg::AGE_LIMIT_RESET;
        send_idle_pct = 13;
        recv_idle_pct = 84;
        hold_cycles = 0;
        mismatches = 0;
        requests_sent = 0;
        results_seen = 0;
        clock_ms = $urandom;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_fill_and_replace();
        test_age_limits();
        test_random();
        test_backpressure();
        drain();

        $display("covered view, mark, clear and expire requests, table fill and replacement,");
        $display("age limit extremes and wrapping time: %0d requests, %0d results, %0d bad",
                 requests_sent, results_seen, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
